[sv/tspq_pkg.sv]
// Package with the types, constants and codes shared by the timestamp priority queue.
`timescale 1ns / 1ps

package tspq_pkg;

    localparam int DEPTH       = 16;
    localparam int TIME_BITS   = 15;
    localparam int ID_BITS     = 4;
    localparam int KEY_BITS    = TIME_BITS + ID_BITS;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PEEK   = 2'd2;

    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef struct packed {
        logic [OP_BITS-1:0]   operation;
        logic [ID_BITS-1:0]   req_id;
        logic [TIME_BITS-1:0] req_time;
    } cmd_t;

    typedef struct packed {
        logic                   head_valid;
        logic [ID_BITS-1:0]     head_id;
        logic [TIME_BITS-1:0]   head_time;
        logic [COUNT_BITS-1:0]  occupancy;
        logic [STATUS_BITS-1:0] status;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_DONE
    } state_t;

endpackage

[sv/timestamp_priority_queue.sv]
// Top level of the timestamp priority queue: sequencer, entry store and result register.
//
//   Channel | Signals                    | Direction | Contents
//   cmd     | cmd_valid, cmd_stall, cmd  | in        | operation, req_id, req_time
//   res     | res_valid, res_stall, res  | out       | head entry, occupancy, status
//
// Entries live in one RAM with a single read and a single write port, so an
// insert or remove moves one entry per cycle. An insert shifts each larger
// entry up and puts the new key in the freed slot; a remove shifts each later
// entry down. Every command, also a peek, a dropped insert or a failed remove,
// then reads and captures the head entry and writes the result register.
// Reset empties the queue at once. A stalled result holds and the next command
// may be taken meanwhile; its result waits until the register is free.
`timescale 1ns / 1ps

module timestamp_priority_queue
    import tspq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    state_t                 state_reg, state_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [COUNT_BITS-1:0]  idx_reg, idx_next;
    key_t                   new_key_reg, new_key_next;
    key_t                   head_key_reg, head_key_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    res_t                   res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    logic                   we;
    logic [ADDR_BITS-1:0]   waddr;
    key_t                   wdata;
    logic [ADDR_BITS-1:0]   raddr;
    key_t                   rdata;
    logic                   held_gt;

    logic [COUNT_BITS-1:0]  idx_m1;
    logic [COUNT_BITS-1:0]  idx_m2;
    logic [COUNT_BITS-1:0]  idx_p1;
    logic [COUNT_BITS-1:0]  idx_p2;
    logic [COUNT_BITS-1:0]  count_m1;

    assign idx_m1   = idx_reg - COUNT_BITS'(1);
    assign idx_m2   = idx_reg - COUNT_BITS'(2);
    assign idx_p1   = idx_reg + COUNT_BITS'(1);
    assign idx_p2   = idx_reg + COUNT_BITS'(2);
    assign count_m1 = count_reg - COUNT_BITS'(1);

    tspq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    tspq_cmp u_cmp (
        .held_key (rdata),
        .new_key  (new_key_reg),
        .gt       (held_gt)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        new_key_reg  <= new_key_next;
        head_key_reg <= head_key_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        new_key_next   = new_key_reg;
        head_key_next  = head_key_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        we             = 1'b0;
        waddr          = idx_reg[ADDR_BITS-1:0];
        wdata          = new_key_reg;
        raddr          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    new_key_next = {cmd.req_time, cmd.req_id};
                    status_next  = STAT_OK;
                    state_next   = S_HEAD_RD;
                    case (cmd.operation)
                        OP_INSERT:
                        begin
                            if (count_reg == COUNT_BITS'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + COUNT_BITS'(1);
                                idx_next   = count_reg;
                                state_next = (count_reg == '0) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                                idx_next   = '0;
                                if (count_reg != COUNT_BITS'(1))
                                begin
                                    state_next = S_REM_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_HEAD_RD;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                raddr      = idx_m1[ADDR_BITS-1:0];
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                we = 1'b1;
                if (held_gt)
                begin
                    wdata    = rdata;
                    idx_next = idx_m1;
                    if (idx_reg == COUNT_BITS'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        raddr = idx_m2[ADDR_BITS-1:0];
                    end
                end
                else
                begin
                    state_next = S_HEAD_RD;
                end
            end
            S_INS_PUT:
            begin
                we         = 1'b1;
                state_next = S_HEAD_RD;
            end
            S_REM_RD:
            begin
                raddr      = idx_p1[ADDR_BITS-1:0];
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                we    = 1'b1;
                wdata = rdata;
                if (idx_p1 == count_reg)
                begin
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    raddr    = idx_p2[ADDR_BITS-1:0];
                    idx_next = idx_p1;
                end
            end
            S_HEAD_RD:
            begin
                raddr      = '0;
                state_next = S_HEAD_CAP;
            end
            S_HEAD_CAP:
            begin
                head_key_next = rdata;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.head_valid = (count_reg != '0);
                    res_next.head_id    = (count_reg != '0) ? head_key_reg[ID_BITS-1:0]
                                                            : '0;
                    res_next.head_time  = (count_reg != '0)
                                          ? head_key_reg[KEY_BITS-1:ID_BITS] : '0;
                    res_next.occupancy  = count_reg;
                    res_next.status     = status_reg;
                    res_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/tspq_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module tspq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/tspq_cmp.sv]
// Key comparator shared by every step of the insertion scan.
`timescale 1ns / 1ps

module tspq_cmp
    import tspq_pkg::*;
(
    input  key_t held_key,
    input  key_t new_key,
    output logic gt
);

    // The timestamp sits above the id, so one compare gives the (time, id) order.
    assign gt = (held_key > new_key);

endmodule
